/* src/bfd_pkg.sv */
`default_nettype none

package bfd_pkg;

   localparam int unsigned MAX_DEST_WIDTH_DEF = 1024;

   localparam int unsigned PIXEL_W   = 8;
   localparam int unsigned HSUM_W    = 10;
   localparam int unsigned ROWVAL_W  = 11;
   localparam int unsigned CSUM_W    = 12;
   localparam int unsigned ACC_W     = 13;
   localparam int unsigned PHASE_W   = 2;
   localparam int unsigned DWIDTH_W  = 11;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [DWIDTH_W-1:0] DEST_WIDTH_RST = 11'd1024;
   localparam logic [PHASE_W-1:0]  LAST_PHASE_2X2 = 2'd1;
   localparam logic [PHASE_W-1:0]  LAST_PHASE_4X4 = 2'd3;
   localparam logic [PIXEL_W-1:0]  PIXEL_MAX      = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FACTOR_MODE = 1'b0,
      CSR_DEST_WIDTH  = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

/* src/box_filter_decimator.sv */
// A result appears on rsp_ once the transaction carrying the bottom-right pixel of
//    its block passes stage 1 (line buffer read register) and the result register.
// Throughput: 1 pixel per clock while rsp_ back-pressure does not stall stage 1; the line buffer read is registered.
// Reset: synchronous, active high; clears counters, pipeline valids, factor_mode (2x2)
//    and dest_width (1024). Line buffer is not cleared and needs no clearing pass.
`default_nettype none

module box_filter_decimator
   import bfd_pkg::*;
#(
   parameter int unsigned MAX_DEST_WIDTH = MAX_DEST_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [PIXEL_W-1:0]   req_tdata,   // [7:0] pixel
   input  wire logic                 req_tuser,   // [0] frame_start
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [PIXEL_W-1:0]        rsp_tdata,   // [7:0] out_pixel
   output logic                      rsp_tlast,
   input  wire logic                 csr_wen,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DWIDTH_W-1:0]  csr_wdata
);

   localparam int unsigned CW    = $clog2(MAX_DEST_WIDTH);
   localparam int unsigned CMP_W = (CW + 1 > DWIDTH_W) ? CW + 1 : DWIDTH_W;
   localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_DEST_WIDTH);

   // configuration
   logic                 mode_ff, mode_in;
   logic [DWIDTH_W-1:0]  dwidth_ff, dwidth_in;

   // stage 0 state
   logic [HSUM_W-1:0]    hsum_ff, hsum_in;
   logic [PHASE_W-1:0]   col_phase_ff, col_phase_in;
   logic [PHASE_W-1:0]   row_phase_ff, row_phase_in;
   logic [CW-1:0]        col_ff, col_in;

   // stage 1
   logic                 s1_valid_ff, s1_valid_in;
   logic [ROWVAL_W-1:0]  s1_rowval_ff;
   logic                 s1_use_prev_ff;
   logic                 s1_row_last_ff;
   logic                 s1_col_last_ff;
   logic [CW-1:0]        s1_addr_ff;
   logic [CSUM_W-1:0]    rd_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]   rsp_pixel_ff;
   logic                 rsp_last_ff;

   logic [CSUM_W-1:0]    col_sums [MAX_DEST_WIDTH];

   logic                 req_fire, s1_adv;
   logic [PHASE_W-1:0]   last_phase, col_phase_cur, row_phase_cur;
   logic [HSUM_W-1:0]    hsum_cur;
   logic [CW-1:0]        col_cur, col_eff;
   logic [ROWVAL_W-1:0]  hs, rowval;
   logic                 row_done, row_last, col_last;
   logic [CMP_W-1:0]     ew;
   logic [CSUM_W-1:0]    prev, wr_data;
   logic [ACC_W-1:0]     acc, res;
   logic [PIXEL_W-1:0]   res_sat;

   // configuration decode
   always_comb begin
      mode_in   = mode_ff;
      dwidth_in = dwidth_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_FACTOR_MODE: mode_in   = csr_wdata[0];
            CSR_DEST_WIDTH:  dwidth_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (dwidth_ff == '0) begin
         ew = CMP_W'(1);
      end else if (CMP_W'(dwidth_ff) > MAX_W) begin
         ew = MAX_W;
      end else begin
         ew = CMP_W'(dwidth_ff);
      end
   end

   // stage 0: counters and horizontal sum
   assign last_phase    = mode_ff ? LAST_PHASE_4X4 : LAST_PHASE_2X2;
   assign col_phase_cur = req_tuser ? '0 : col_phase_ff;
   assign row_phase_cur = req_tuser ? '0 : row_phase_ff;
   assign hsum_cur      = req_tuser ? '0 : hsum_ff;
   assign col_cur       = req_tuser ? '0 : col_ff;
   assign hs            = ((col_phase_cur == '0) ? '0 : ROWVAL_W'(hsum_cur))
                          + ROWVAL_W'(req_tdata);
   assign row_done      = col_phase_cur >= last_phase;
   assign col_eff       = (CMP_W'(col_cur) >= MAX_W) ? '0 : col_cur;
   assign rowval        = mode_ff ? hs : (hs >> 1);
   assign row_last      = row_phase_cur >= last_phase;
   assign col_last      = (CMP_W'(col_eff) + CMP_W'(1)) >= ew;

   assign s1_adv     = s1_valid_ff && (!s1_row_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      hsum_in      = hsum_ff;
      col_phase_in = col_phase_ff;
      row_phase_in = row_phase_ff;
      col_in       = col_ff;
      if (req_fire) begin
         if (!row_done) begin
            hsum_in      = hs[HSUM_W-1:0];
            col_phase_in = col_phase_cur + PHASE_W'(1);
            row_phase_in = row_phase_cur;
            col_in       = col_cur;
         end else begin
            hsum_in      = '0;
            col_phase_in = '0;
            if (col_last) begin
               col_in       = '0;
               row_phase_in = row_last ? '0 : row_phase_cur + PHASE_W'(1);
            end else begin
               col_in       = col_eff + CW'(1);
               row_phase_in = row_phase_cur;
            end
         end
      end
   end

   // stage 1: vertical accumulation
   assign prev    = s1_use_prev_ff ? rd_ff : '0;
   assign acc     = ACC_W'(prev) + ACC_W'(s1_rowval_ff);
   assign wr_data = mode_ff ? acc[CSUM_W-1:0] : CSUM_W'(s1_rowval_ff);
   assign res     = mode_ff ? (acc >> 4) : (acc >> 1);
   assign res_sat = (res > ACC_W'(PIXEL_MAX)) ? PIXEL_MAX : res[PIXEL_W-1:0];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = row_done;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && s1_row_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         dwidth_ff    <= DEST_WIDTH_RST;
         hsum_ff      <= '0;
         col_phase_ff <= '0;
         row_phase_ff <= '0;
         col_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         dwidth_ff    <= dwidth_in;
         hsum_ff      <= hsum_in;
         col_phase_ff <= col_phase_in;
         row_phase_ff <= row_phase_in;
         col_ff       <= col_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && row_done) begin
         s1_rowval_ff   <= rowval;
         s1_use_prev_ff <= row_phase_cur != '0;
         s1_row_last_ff <= row_last;
         s1_col_last_ff <= col_last;
         s1_addr_ff     <= col_eff;
      end
      if (s1_adv && s1_row_last_ff) begin
         rsp_pixel_ff <= res_sat;
         rsp_last_ff  <= s1_col_last_ff;
      end
   end

   // line buffer
   always_ff @(posedge clock) begin
      if (req_fire && row_done) begin
         rd_ff <= col_sums[col_eff];
      end
      if (s1_adv && !s1_row_last_ff) begin
         col_sums[s1_addr_ff] <= wr_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_row_done_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && row_done |=> col_phase_ff == '0 && hsum_ff == '0)
      else $error("block row end did not clear column phase");

   a_row_end_wraps: assert property (@(posedge clock) disable iff (reset)
      req_fire && row_done && col_last |=> col_ff == '0)
      else $error("last column did not wrap output column");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_rowval_ff))
      else $error("stalled stage 1 item lost");

   a_no_back_to_back_read: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> !req_fire)
      else $error("item accepted while stage 1 blocked");

endmodule

`default_nettype wire
